FILE: rtl/jpeg_marker_segment_scanner_macros.svh
// Assertion macros shared by the scanner's checker.
`ifndef JPEG_MARKER_SEGMENT_SCANNER_MACROS_SVH
`define JPEG_MARKER_SEGMENT_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JMS_ASSERT_NOW(name, clk, rstn, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("jms assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JMS_ASSERT_NEXT(name, clk, rstn, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("jms assertion failed");

`endif

FILE: rtl/jms_pkg.sv
// Types, codes and the marker decoder of the JPEG marker segment scanner.
`timescale 1ns / 1ps

package jms_pkg;

    // Scan phases
    localparam logic [2:0] PH_STOPPED = 3'd0;
    localparam logic [2:0] PH_MARK    = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // Marker indexes
    localparam logic [3:0] MK_SOI  = 4'd0;
    localparam logic [3:0] MK_EOI  = 4'd1;
    localparam logic [3:0] MK_SOF0 = 4'd2;
    localparam logic [3:0] MK_SOS  = 4'd3;
    localparam logic [3:0] MK_DQT  = 4'd4;
    localparam logic [3:0] MK_DRI  = 4'd5;
    localparam logic [3:0] MK_APP0 = 4'd6;
    localparam logic [3:0] MK_RST0 = 4'd7;
    localparam logic [3:0] MK_RST7 = 4'd14;
    localparam logic [3:0] MK_NONE = 4'd15;

    // Result kinds
    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_QUANT = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_ALIGN     = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN   = 2'd2;
    localparam logic [1:0] ERR_BAD_LEN   = 2'd3;

    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_00 = 8'h00;
    localparam int         QUANT_ENTRIES = 64;
    localparam int         POS_W = 7;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_start;
        logic       frame_end;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  marker_index;
        logic [1:0]  error_code;
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic [15:0] restart_interval;
        logic        quant_table;
        logic [5:0]  quant_index;
        logic [7:0]  quant_value;
    } out_word_t;

    typedef struct packed {
        logic      produce;
        out_word_t word;
    } scan_result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] index;
    } marker_hit_t;

    // Decode the byte that follows FF into a marker index.
    function automatic marker_hit_t marker_lookup(input logic [7:0] b);
        marker_hit_t r;
        r.hit   = 1'b1;
        r.index = MK_SOI;
        unique case (b) inside
            [8'hD0:8'hD7]: r.index = MK_RST0 + {1'b0, b[2:0]};
            8'hD8:         r.index = MK_SOI;
            8'hD9:         r.index = MK_EOI;
            8'hC0:         r.index = MK_SOF0;
            8'hDA:         r.index = MK_SOS;
            8'hDB:         r.index = MK_DQT;
            8'hDD:         r.index = MK_DRI;
            8'hE0:         r.index = MK_APP0;
            default:       r.hit   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/jms_in_stage.sv
// Input register of the scanner: holds one word until the scan stage takes it.
`timescale 1ns / 1ps

module jms_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jms_pkg::in_word_t s_word,
    input  logic              advance,
    output logic              word_valid,
    output jms_pkg::in_word_t word
);

    logic              valid_reg;
    logic              valid_next;
    jms_pkg::in_word_t word_reg;

    // Take a new word when empty or when the held word moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload; no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

FILE: rtl/jms_scan.sv
// Scan state and the per-byte next-state and result logic.
`timescale 1ns / 1ps

module jms_scan (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  jms_pkg::in_word_t     word,
    output jms_pkg::scan_result_t result
);

    logic [2:0]              phase_reg, phase_next;
    logic [3:0]              prev_reg, prev_next;
    logic [3:0]              cur_reg, cur_next;
    logic [15:0]             left_reg, left_next;
    logic [jms_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                    ff_reg, ff_next;
    logic [15:0]             height_reg, height_next;
    logic [15:0]             width_reg, width_next;
    logic [15:0]             interval_reg, interval_next;
    logic                    tsel_reg, tsel_next;

    // Values seen by this byte after a frame start clears the scan
    logic [2:0]              phase_eff;
    logic [3:0]              prev_eff;
    logic [3:0]              cur_eff;
    logic [15:0]             left_eff;
    logic [jms_pkg::POS_W-1:0] pos_eff;
    logic                    ff_eff;
    logic                    tsel_eff;

    logic [7:0]              b;
    logic                    entropy;
    logic [1:0]              err;
    logic                    done;
    logic                    quant;
    logic [5:0]              qidx;
    logic [15:0]             seg_len;
    jms_pkg::marker_hit_t    mk;

    assign b = word.byte_value;

    always_comb begin
        phase_eff = word.frame_start ? jms_pkg::PH_MARK : phase_reg;
        prev_eff  = word.frame_start ? jms_pkg::MK_NONE : prev_reg;
        cur_eff   = word.frame_start ? jms_pkg::MK_SOI : cur_reg;
        left_eff  = word.frame_start ? 16'd0 : left_reg;
        pos_eff   = word.frame_start ? '0 : pos_reg;
        ff_eff    = word.frame_start ? 1'b0 : ff_reg;
        tsel_eff  = word.frame_start ? 1'b0 : tsel_reg;
    end

    assign entropy = (prev_eff == jms_pkg::MK_SOS) ||
                     ((prev_eff >= jms_pkg::MK_RST0) && (prev_eff <= jms_pkg::MK_RST7));
    assign mk      = jms_pkg::marker_lookup(b);
    assign seg_len = {left_eff[15:8], b};

    // Step the scan by one byte
    always_comb begin
        phase_next    = phase_eff;
        prev_next     = prev_eff;
        cur_next      = cur_eff;
        left_next     = left_eff;
        pos_next      = pos_eff;
        ff_next       = ff_eff;
        tsel_next     = tsel_eff;
        height_next   = height_reg;
        width_next    = width_reg;
        interval_next = interval_reg;
        err           = jms_pkg::ERR_NONE;
        done          = 1'b0;
        quant         = 1'b0;
        qidx          = 6'd0;

        unique case (phase_eff)
            jms_pkg::PH_MARK: begin
                if (!ff_eff) begin
                    if (b == jms_pkg::BYTE_FF) begin
                        ff_next = 1'b1;
                    end else if (!entropy) begin
                        err = jms_pkg::ERR_ALIGN;
                    end
                end else begin
                    ff_next = 1'b0;
                    // A stuffed zero inside entropy data is plain data
                    if (!(b == jms_pkg::BYTE_00 && entropy)) begin
                        if (!mk.hit) begin
                            err = jms_pkg::ERR_UNKNOWN;
                        end else begin
                            cur_next = mk.index;
                            if (mk.index >= jms_pkg::MK_SOF0 &&
                                mk.index <= jms_pkg::MK_APP0) begin
                                phase_next = jms_pkg::PH_LEN_HI;
                            end else begin
                                done      = 1'b1;
                                prev_next = mk.index;
                            end
                        end
                    end
                end
            end
            jms_pkg::PH_LEN_HI: begin
                left_next  = {b, 8'h00};
                phase_next = jms_pkg::PH_LEN_LO;
            end
            jms_pkg::PH_LEN_LO: begin
                if (seg_len < 16'd2) begin
                    err = jms_pkg::ERR_BAD_LEN;
                end else begin
                    left_next = seg_len - 16'd2;
                    pos_next  = '0;
                    if (seg_len == 16'd2) begin
                        done       = 1'b1;
                        prev_next  = cur_eff;
                        phase_next = jms_pkg::PH_MARK;
                    end else begin
                        phase_next = jms_pkg::PH_PAYLOAD;
                    end
                end
            end
            jms_pkg::PH_PAYLOAD: begin
                // Pick header fields out of the payload
                if (cur_eff == jms_pkg::MK_SOF0) begin
                    if (pos_eff == 7'd1) height_next[15:8] = b;
                    if (pos_eff == 7'd2) height_next[7:0]  = b;
                    if (pos_eff == 7'd3) width_next[15:8]  = b;
                    if (pos_eff == 7'd4) width_next[7:0]   = b;
                end else if (cur_eff == jms_pkg::MK_DRI) begin
                    if (pos_eff == 7'd0) interval_next[15:8] = b;
                    if (pos_eff == 7'd1) interval_next[7:0]  = b;
                end else if (cur_eff == jms_pkg::MK_DQT) begin
                    if (pos_eff == 7'd0) begin
                        tsel_next = (b[3:0] != 4'd0);
                    end else if (pos_eff <= jms_pkg::POS_W'(jms_pkg::QUANT_ENTRIES)) begin
                        quant = 1'b1;
                        qidx  = 6'(pos_eff - 7'd1);
                    end
                end
                // Saturate the position once past every field of interest
                if (pos_eff != '1) begin
                    pos_next = pos_eff + 7'd1;
                end
                left_next = left_eff - 16'd1;
                if (left_eff == 16'd1) begin
                    done       = 1'b1;
                    prev_next  = cur_eff;
                    phase_next = jms_pkg::PH_MARK;
                end
            end
            default: begin
                // Stopped: drop the byte
            end
        endcase

        result.produce                 = 1'b0;
        result.word.result_kind        = jms_pkg::KIND_DONE;
        result.word.marker_index       = cur_next;
        result.word.error_code         = err;
        result.word.image_height       = height_next;
        result.word.image_width        = width_next;
        result.word.restart_interval   = interval_next;
        result.word.quant_table        = 1'b0;
        result.word.quant_index        = 6'd0;
        result.word.quant_value        = 8'd0;

        // Pick one result: error, then end, then quant entry, then done
        if (err != jms_pkg::ERR_NONE) begin
            phase_next                 = jms_pkg::PH_STOPPED;
            result.produce             = 1'b1;
            result.word.result_kind    = jms_pkg::KIND_ERROR;
            result.word.marker_index   = jms_pkg::MK_SOI;
        end else if (phase_eff != jms_pkg::PH_STOPPED && word.frame_end) begin
            phase_next                 = jms_pkg::PH_STOPPED;
            result.produce             = 1'b1;
            result.word.result_kind    = jms_pkg::KIND_END;
        end else if (quant) begin
            result.produce             = 1'b1;
            result.word.result_kind    = jms_pkg::KIND_QUANT;
            result.word.marker_index   = jms_pkg::MK_DQT;
            result.word.quant_table    = tsel_next;
            result.word.quant_index    = qidx;
            result.word.quant_value    = b;
        end else if (done) begin
            result.produce             = 1'b1;
        end
    end

    // Commit the step when the byte leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= jms_pkg::PH_STOPPED;
            prev_reg     <= jms_pkg::MK_NONE;
            cur_reg      <= jms_pkg::MK_SOI;
            left_reg     <= 16'd0;
            pos_reg      <= '0;
            ff_reg       <= 1'b0;
            height_reg   <= 16'd0;
            width_reg    <= 16'd0;
            interval_reg <= 16'd0;
            tsel_reg     <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            prev_reg     <= prev_next;
            cur_reg      <= cur_next;
            left_reg     <= left_next;
            pos_reg      <= pos_next;
            ff_reg       <= ff_next;
            height_reg   <= height_next;
            width_reg    <= width_next;
            interval_reg <= interval_next;
            tsel_reg     <= tsel_next;
        end
    end

endmodule

FILE: rtl/jms_out_stage.sv
// Result register of the scanner.
`timescale 1ns / 1ps

module jms_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  jms_pkg::scan_result_t result,
    output logic                  can_take,
    output logic                  m_valid,
    input  logic                  m_ready,
    output jms_pkg::out_word_t    m_word
);

    logic               valid_reg;
    logic               valid_next;
    jms_pkg::out_word_t word_reg;

    // Free when empty or when the held word is taken this cycle
    assign can_take = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = result.produce;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.produce) begin
            word_reg <= result.word;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

FILE: rtl/jpeg_marker_segment_scanner.sv
// Top level of the JPEG marker segment scanner.
//
//  channel | ports                      | word type
//  input   | s_valid, s_ready, s_word   | jms_pkg::in_word_t  (one frame byte)
//  result  | m_valid, m_ready, m_word   | jms_pkg::out_word_t (zero or one per byte)
//
// One byte per clock while the result register is not stalled; a result reaches m_word
// through the input register, then scan logic into the result register.
// Reset (aresetn low, synchronous) empties both registers and stops the scan
// until a byte flagged frame_start arrives.
// A stalled result register holds the byte in the input register, and s_ready drops
// only while both registers are full and m_ready is low.
`timescale 1ns / 1ps

module jpeg_marker_segment_scanner (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jms_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output jms_pkg::out_word_t m_word
);

    logic                  word_valid;
    jms_pkg::in_word_t     word;
    logic                  can_take;
    logic                  advance;
    jms_pkg::scan_result_t result;

    // Advance the held byte when the result register can take its outcome
    assign advance = word_valid && can_take;

    jms_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    jms_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .word    (word),
        .result  (result)
    );

    jms_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .can_take (can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

endmodule

FILE: rtl/jms_checker.sv
// Port-level checker for the scanner, bound to the top level.
`timescale 1ns / 1ps
`include "jpeg_marker_segment_scanner_macros.svh"

module jms_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input jms_pkg::out_word_t m_word
);

    logic is_quant;
    logic is_error;
    logic has_err_code;
    logic quant_clear;
    logic dqt_mark;

    // Classify the result word
    assign is_quant     = m_word.result_kind == jms_pkg::KIND_QUANT;
    assign is_error     = m_word.result_kind == jms_pkg::KIND_ERROR;
    assign has_err_code = m_word.error_code != jms_pkg::ERR_NONE;
    assign quant_clear  = m_word.quant_table == 1'b0 && m_word.quant_index == 6'd0 &&
                          m_word.quant_value == 8'd0;
    assign dqt_mark     = m_word.marker_index == jms_pkg::MK_DQT;

    // A stalled result word stays up and unchanged
    `JMS_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `JMS_ASSERT_NEXT(a_hold_word, aclk, aresetn, m_valid && !m_ready, $stable(m_word))

    // Quantization fields are zero unless the word is a quant entry
    `JMS_ASSERT_NOW(a_quant_zero, aclk, aresetn, m_valid && !is_quant, quant_clear)

    // Error code and marker agree with the result kind
    `JMS_ASSERT_NOW(a_err_kind, aclk, aresetn, m_valid, is_error == has_err_code)
    `JMS_ASSERT_NOW(a_quant_mark, aclk, aresetn, m_valid && is_quant, dqt_mark)

endmodule

bind jpeg_marker_segment_scanner jms_checker u_jms_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
